### src/constant_pad_address_map_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the padding address map RTL.
// ----------------------------------------------------------------------------
`ifndef CONSTANT_PAD_ADDRESS_MAP_MACROS_SVH
`define CONSTANT_PAD_ADDRESS_MAP_MACROS_SVH
`ifndef ASSERT_OFF
// Checked property, switched off while reset is asserted.
`define CPAM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property that also holds across reset.
`define CPAM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPAM_ASSERT(lbl, clk, rstn, prop, msg)
`define CPAM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### src/cpam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpam_pkg
// Shared constants and register codes of the padding address map.
// ----------------------------------------------------------------------------
package cpam_pkg;

    localparam int MAX_DIMS_DEF = 4;
    localparam int DIM_BITS_DEF = 16;
    localparam int INDEX_W      = 32;
    localparam int DATA_W       = 64;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int NDIM_W       = 3;
    // Quotient bits resolved in each divider stage.
    localparam int QUOT_STEP    = 2;
    localparam int DIV_STAGES   = INDEX_W / QUOT_STEP;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_DIMS   = 3'd0,
        CFG_IN_SIZES   = 3'd1,
        CFG_OUT_SIZES  = 3'd2,
        CFG_LEAD_PADS  = 3'd3,
        CFG_FILL_VALUE = 3'd4
    } t_cfg_reg;

    // Handshake control of each divider stage.
    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

endpackage

### src/constant_pad_address_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// constant_pad_address_map
// Address generator for constant padding of a row-major tensor.
// ----------------------------------------------------------------------------
// The block accepts one transfer per clock cycle unless a stall at the output
// holds it, and delivers one result per transfer, in order. Each item passes
// through the whole pipeline, which is made up first of the chain of
// divider stages, each resolving two quotient bits of the 32-bit index for one
// dimension, followed by one multiply-accumulate stage per dimension that builds
// the padded row-major offset. A fill request travels the same pipeline with
// every divisor forced to one, so its offset comes out unchanged. A copy whose
// index is at or beyond the input element count is flagged on tuser with a
// zero offset and zero data; the check is whether any quotient is left once
// the index has been divided by every size in use, or whether a size in use is
// zero. A stall at the output freezes the whole pipeline, so nothing is lost or
// repeated. Configuration is written through a plain write port and must only
// be changed while the pipeline is empty.
// ----------------------------------------------------------------------------
`include "constant_pad_address_map_macros.svh"

module constant_pad_address_map #(
    parameter int MAX_DIMS = cpam_pkg::MAX_DIMS_DEF,
    parameter int DIM_BITS = cpam_pkg::DIM_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_wr_en,
    input  logic [cpam_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cpam_pkg::CFG_W-1:0]      i_cfg_data,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [95:0] i_s_axis_tdata,   // elem_index [31:0], elem_value [95:32]
    input  logic        i_s_axis_tuser,   // func: 0 fill, 1 copy
    // Output stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [95:0] o_m_axis_tdata,   // dest_offset [31:0], dest_value [95:32]
    output logic        o_m_axis_tuser    // bad_index
);

    localparam int IW     = cpam_pkg::INDEX_W;
    localparam int DW     = cpam_pkg::DATA_W;
    localparam int DS     = cpam_pkg::DIV_STAGES;
    localparam int NSTEP  = MAX_DIMS * DS;
    localparam int SIDE_W = 1 + DW + MAX_DIMS * DIM_BITS;
    localparam int CRD_LO = 1 + DW;

    // Configuration registers.
    logic [cpam_pkg::NDIM_W-1:0] r_num_dims;
    logic [cpam_pkg::CFG_W-1:0]  r_in_sizes, r_out_sizes, r_lead_pads, r_fill_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims   <= '0;
            r_in_sizes   <= '0;
            r_out_sizes  <= '0;
            r_lead_pads  <= '0;
            r_fill_value <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (cpam_pkg::t_cfg_reg'(i_cfg_index))
                cpam_pkg::CFG_NUM_DIMS:   r_num_dims   <= i_cfg_data[cpam_pkg::NDIM_W-1:0];
                cpam_pkg::CFG_IN_SIZES:   r_in_sizes   <= i_cfg_data;
                cpam_pkg::CFG_OUT_SIZES:  r_out_sizes  <= i_cfg_data;
                cpam_pkg::CFG_LEAD_PADS:  r_lead_pads  <= i_cfg_data;
                cpam_pkg::CFG_FILL_VALUE: r_fill_value <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Dimensions in use, with a count above MAX_DIMS treated as MAX_DIMS.
    logic [MAX_DIMS-1:0] dim_used;
    logic [MAX_DIMS-1:0] size_zero;
    logic                any_zero;

    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
        assign dim_used[d]  = int'(r_num_dims) > d;
        assign size_zero[d] = r_in_sizes[d*DIM_BITS +: DIM_BITS] == '0;
    end
    assign any_zero = |(dim_used & size_zero);

    // The whole pipeline advances unless the output holds a result not yet taken.
    logic pipe_en;
    logic r_h_valid [MAX_DIMS];

    assign pipe_en         = !r_h_valid[MAX_DIMS-1] || i_m_axis_tready;
    assign o_s_axis_tready = pipe_en;

    // Divider chain: section k divides by the size of dimension MAX_DIMS-1-k.
    logic              w_valid [NSTEP+1];
    logic [IW-1:0]     w_nq    [NSTEP+1];
    logic [DIM_BITS-1:0] w_rem [NSTEP+1];
    logic [SIDE_W-1:0] w_side  [NSTEP+1];

    assign w_valid[0] = i_s_axis_tvalid;
    assign w_nq[0]    = i_s_axis_tdata[IW-1:0];
    assign w_rem[0]   = '0;
    assign w_side[0]  = {{(MAX_DIMS*DIM_BITS){1'b0}}, i_s_axis_tdata[IW +: DW],
                         i_s_axis_tuser};

    for (genvar s = 0; s < NSTEP; s++) begin : g_div
        localparam int K = s / DS;
        localparam int D = MAX_DIMS - 1 - K;

        logic [DIM_BITS-1:0] rem_in;
        logic [DIM_BITS-1:0] div_eff;
        logic [SIDE_W-1:0]   side_in;
        cpam_pkg::t_stage_ctl ctl;

        if (s % DS == 0) begin : g_start
            assign rem_in = '0;
            if (s == 0) begin : g_first
                assign side_in = w_side[s];
            end else begin : g_store
                // Remainder of the finished section is the coordinate of its dimension.
                always_comb begin
                    side_in = w_side[s];
                    side_in[CRD_LO + (D+1)*DIM_BITS +: DIM_BITS] = w_rem[s];
                end
            end
        end else begin : g_mid
            assign rem_in  = w_rem[s];
            assign side_in = w_side[s];
        end

        assign div_eff = (side_in[0] && dim_used[D]) ?
                         r_in_sizes[D*DIM_BITS +: DIM_BITS] : DIM_BITS'(1);
        assign ctl.en    = pipe_en;
        assign ctl.valid = w_valid[s];

        cpam_div_stage #(
            .DIM_BITS (DIM_BITS),
            .SIDE_W   (SIDE_W)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_nq    (w_nq[s]),
            .i_rem   (rem_in),
            .i_div   (div_eff),
            .i_side  (side_in),
            .o_valid (w_valid[s+1]),
            .o_nq    (w_nq[s+1]),
            .o_rem   (w_rem[s+1]),
            .o_side  (w_side[s+1])
        );
    end

    // Horner stages: stage j folds dimension j into the padded offset.
    logic [IW-1:0]     r_h_off   [MAX_DIMS];
    logic [IW-1:0]     r_h_nq    [MAX_DIMS];
    logic              r_h_bad   [MAX_DIMS];
    logic [SIDE_W-1:0] r_h_side  [MAX_DIMS];

    logic [SIDE_W-1:0] div_side;
    logic              div_bad;

    always_comb begin
        div_side = w_side[NSTEP];
        div_side[CRD_LO +: DIM_BITS] = w_rem[NSTEP];
    end
    assign div_bad = div_side[0] && ((w_nq[NSTEP] != '0) || any_zero);

    for (genvar j = 0; j < MAX_DIMS; j++) begin : g_horner
        logic              valid_in, bad_in;
        logic [IW-1:0]     off_in, nq_in, n_off;
        logic [SIDE_W-1:0] side_in;
        logic [IW+DIM_BITS-1:0] prod;
        logic [IW-1:0]     pos;

        if (j == 0) begin : g_head
            assign valid_in = w_valid[NSTEP];
            assign off_in   = '0;
            assign nq_in    = w_nq[NSTEP];
            assign bad_in   = div_bad;
            assign side_in  = div_side;
        end else begin : g_chain
            assign valid_in = r_h_valid[j-1];
            assign off_in   = r_h_off[j-1];
            assign nq_in    = r_h_nq[j-1];
            assign bad_in   = r_h_bad[j-1];
            assign side_in  = r_h_side[j-1];
        end

        assign prod = {{DIM_BITS{1'b0}}, off_in} *
                      {{IW{1'b0}}, r_out_sizes[j*DIM_BITS +: DIM_BITS]};
        assign pos  = {{(IW-DIM_BITS){1'b0}}, r_lead_pads[j*DIM_BITS +: DIM_BITS]} +
                      {{(IW-DIM_BITS){1'b0}}, side_in[CRD_LO + j*DIM_BITS +: DIM_BITS]};
        assign n_off = (side_in[0] && dim_used[j]) ? prod[IW-1:0] + pos : off_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_h_valid[j] <= 1'b0;
            end else if (pipe_en) begin
                r_h_valid[j] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_h_off[j]  <= n_off;
                r_h_nq[j]   <= nq_in;
                r_h_bad[j]  <= bad_in;
                r_h_side[j] <= side_in;
            end
        end
    end

    // Result selection on the last stage.
    logic          out_func;
    logic          out_bad;
    logic [IW-1:0] out_off;
    logic [DW-1:0] out_val;

    assign out_func = r_h_side[MAX_DIMS-1][0];
    assign out_bad  = r_h_bad[MAX_DIMS-1];

    always_comb begin
        if (!out_func) begin
            out_off = r_h_nq[MAX_DIMS-1];
            out_val = r_fill_value;
        end else if (out_bad) begin
            out_off = '0;
            out_val = '0;
        end else begin
            out_off = r_h_off[MAX_DIMS-1];
            out_val = r_h_side[MAX_DIMS-1][1 +: DW];
        end
    end

    assign o_m_axis_tvalid = r_h_valid[MAX_DIMS-1];
    assign o_m_axis_tdata  = {out_val, out_off};
    assign o_m_axis_tuser  = out_bad;

    `CPAM_ASSERT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result valid straight after reset")
    `CPAM_ASSERT(a_bad_is_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0, "flagged result carries data")
    `CPAM_ASSERT(a_bad_only_copy, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser |-> out_func, "fill request flagged as bad")

endmodule

### src/cpam_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpam_div_stage
// One registered step of a restoring divider, resolving QUOT_STEP quotient bits.
// ----------------------------------------------------------------------------
module cpam_div_stage #(
    parameter int DIM_BITS = cpam_pkg::DIM_BITS_DEF,
    parameter int SIDE_W   = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cpam_pkg::t_stage_ctl       i_ctl,
    input  logic [cpam_pkg::INDEX_W-1:0] i_nq,
    input  logic [DIM_BITS-1:0]        i_rem,
    input  logic [DIM_BITS-1:0]        i_div,
    input  logic [SIDE_W-1:0]          i_side,
    output logic                       o_valid,
    output logic [cpam_pkg::INDEX_W-1:0] o_nq,
    output logic [DIM_BITS-1:0]        o_rem,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int IW = cpam_pkg::INDEX_W;

    logic            r_valid;
    logic [IW-1:0]   r_nq, n_nq;
    logic [DIM_BITS-1:0] r_rem, n_rem;
    logic [SIDE_W-1:0]   r_side;

    // The numerator shifts out at the top while quotient bits enter at the bottom.
    always_comb begin
        logic [DIM_BITS:0] trial;
        n_nq  = i_nq;
        n_rem = i_rem;
        for (int k = 0; k < cpam_pkg::QUOT_STEP; k++) begin
            trial = {n_rem, n_nq[IW-1]};
            n_nq  = {n_nq[IW-2:0], 1'b0};
            if (trial >= {1'b0, i_div}) begin
                trial   = trial - {1'b0, i_div};
                n_nq[0] = 1'b1;
            end
            n_rem = trial[DIM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_nq   <= n_nq;
            r_rem  <= n_rem;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_nq    = r_nq;
    assign o_rem   = r_rem;
    assign o_side  = r_side;

endmodule
